// ===== sv/sdkj_pkg.sv =====
package sdkj_pkg;

  localparam int ANGLE_W = 16;
  localparam int ENTRY_W = 32;
  // Internal Q30 value width; holds reduced angles and sums of two unit terms
  localparam int VAL_W = 36;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ANGLE_SHIFT = 33 - ANGLE_W;
  localparam int TAYLOR_TERMS = 7;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [MUL_W-1:0]   mop_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
  } angles_t;

  typedef struct packed {
    logic [2:0] row_index;
    entry_t     entry_first;
    entry_t     entry_second;
    entry_t     entry_third;
    logic       singular;
    logic       last_row;
  } row_res_t;

  localparam val_t HALF_PI      = 36'sd1686629713;
  localparam val_t HALF_PI_HALF = 36'sd843314856;
  // four quadrants plus half a quadrant, so the reduction runs on a positive value
  localparam val_t RED_OFFSET   = 36'sd7589833708;
  localparam val_t ONE_Q30      = 36'sd1073741824;
  localparam val_t ENT_MAX      = val_t'((64'sd1 <<< (ENTRY_W - 1)) - 64'sd1);
  localparam val_t ENT_MIN      = -ENT_MAX - 36'sd1;
  localparam val_t ONE_Q16      = 36'sd65536;
  localparam val_t SING_LIM     = 36'sd8192;

  function automatic val_t rnd_q30(prod_t p);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r = (m + (PROD_W'(1) << 29)) >> 30;
    return p[PROD_W-1] ? -val_t'(r[VAL_W-1:0]) : val_t'(r[VAL_W-1:0]);
  endfunction

  function automatic entry_t sat_entry(val_t s);
    val_t c;
    c = s;
    if (s > ENT_MAX) c = ENT_MAX;
    if (s < ENT_MIN) c = ENT_MIN;
    return entry_t'(c[ENTRY_W-1:0]);
  endfunction

  // Q30 to Q16, round half away from zero, then saturate
  function automatic entry_t q30_entry(val_t v);
    logic [VAL_W-1:0] m;
    logic [VAL_W-1:0] r;
    val_t s;
    m = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    r = (m + (VAL_W'(1) << 13)) >> 14;
    s = v[VAL_W-1] ? -val_t'(r) : val_t'(r);
    return sat_entry(s);
  endfunction

  // Taylor step divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic logic [7:0] taylor_div(logic [2:0] k, logic is_cos);
    logic [7:0] d;
    case ({is_cos, k})
      4'b0001: d = 8'd6;
      4'b0010: d = 8'd20;
      4'b0011: d = 8'd42;
      4'b0100: d = 8'd72;
      4'b0101: d = 8'd110;
      4'b0110: d = 8'd156;
      4'b0111: d = 8'd210;
      4'b1001: d = 8'd2;
      4'b1010: d = 8'd12;
      4'b1011: d = 8'd30;
      4'b1100: d = 8'd56;
      4'b1101: d = 8'd90;
      4'b1110: d = 8'd132;
      4'b1111: d = 8'd182;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] taylor_recip(logic [2:0] k, logic is_cos);
    logic [31:0] r;
    case ({is_cos, k})
      4'b0001: r = 32'd715827882;
      4'b0010: r = 32'd214748364;
      4'b0011: r = 32'd102261126;
      4'b0100: r = 32'd59652323;
      4'b0101: r = 32'd39045157;
      4'b0110: r = 32'd27531841;
      4'b0111: r = 32'd20452225;
      4'b1001: r = 32'd2147483648;
      4'b1010: r = 32'd357913941;
      4'b1011: r = 32'd143165576;
      4'b1100: r = 32'd76695844;
      4'b1101: r = 32'd47721858;
      4'b1110: r = 32'd32537631;
      4'b1111: r = 32'd23598721;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sdkj_front.sv =====
module sdkj_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  sdkj_pkg::angles_t item,
  output logic              head_valid,
  output sdkj_pkg::angles_t head,
  input  logic              take
);

  sdkj_pkg::angles_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_take;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= item;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (do_take) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_take) cnt_r <= cnt_r + 2'd1;
      else if (!do_push && do_take) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== sv/sdkj_trig.sv =====
module sdkj_trig (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sdkj_pkg::angle_t angle,
  output logic             done,
  output sdkj_pkg::val_t   sin_o,
  output sdkj_pkg::val_t   cos_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_SQ_M, S_SQ_R, S_TM, S_TR, S_DM, S_DE, S_DC, S_ROT
  } state_t;

  state_t            state_r;
  sdkj_pkg::val_t    xr_r;
  logic [2:0]        q_r;
  sdkj_pkg::val_t    r_r;
  sdkj_pkg::val_t    r2_r;
  sdkj_pkg::val_t    st_r;
  sdkj_pkg::val_t    ct_r;
  sdkj_pkg::val_t    ss_r;
  sdkj_pkg::val_t    cs_r;
  logic [2:0]        k_r;
  logic              cos_sel_r;
  sdkj_pkg::prod_t   prod_r;
  logic [31:0]       mag_r;
  logic              neg_r;
  logic [31:0]       est_r;

  sdkj_pkg::mop_t    mul_a;
  sdkj_pkg::mop_t    mul_b;
  sdkj_pkg::prod_t   mul_p;
  sdkj_pkg::val_t    p_val;
  logic [7:0]        dsel;
  logic [31:0]       rsel;
  logic [39:0]       est_d;
  logic [39:0]       chk;
  logic [31:0]       qv;
  sdkj_pkg::val_t    term;

  assign dsel = sdkj_pkg::taylor_div(k_r, cos_sel_r);
  assign rsel = sdkj_pkg::taylor_recip(k_r, cos_sel_r);

  always_comb begin
    case (state_r)
      S_SQ_M: begin
        mul_a = sdkj_pkg::mop_t'(r_r);
        mul_b = sdkj_pkg::mop_t'(r_r);
      end
      S_TM: begin
        mul_a = cos_sel_r ? sdkj_pkg::mop_t'(ct_r) : sdkj_pkg::mop_t'(st_r);
        mul_b = sdkj_pkg::mop_t'(r2_r);
      end
      S_DM: begin
        mul_a = sdkj_pkg::mop_t'({1'b0, mag_r});
        mul_b = sdkj_pkg::mop_t'({1'b0, rsel});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign p_val = sdkj_pkg::rnd_q30(prod_r);

  // reciprocal estimate is at most one low; one compare fixes it
  assign est_d = 40'(est_r) * 40'(dsel);
  assign chk   = 40'(mag_r) - est_d;
  assign qv    = est_r + 32'(chk >= 40'(dsel));
  assign term  = neg_r ? sdkj_pkg::val_t'(qv) : -sdkj_pkg::val_t'(qv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            xr_r    <= (sdkj_pkg::val_t'(angle) <<< sdkj_pkg::ANGLE_SHIFT)
                       + sdkj_pkg::RED_OFFSET;
            q_r     <= 3'd0;
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (xr_r >= sdkj_pkg::HALF_PI) begin
            xr_r <= xr_r - sdkj_pkg::HALF_PI;
            q_r  <= q_r + 3'd1;
          end else begin
            r_r     <= xr_r - sdkj_pkg::HALF_PI_HALF;
            state_r <= S_SQ_M;
          end
        end
        S_SQ_M: begin
          prod_r  <= mul_p;
          state_r <= S_SQ_R;
        end
        S_SQ_R: begin
          r2_r      <= p_val;
          st_r      <= r_r;
          ss_r      <= r_r;
          ct_r      <= sdkj_pkg::ONE_Q30;
          cs_r      <= sdkj_pkg::ONE_Q30;
          k_r       <= 3'd1;
          cos_sel_r <= 1'b0;
          state_r   <= S_TM;
        end
        S_TM: begin
          prod_r  <= mul_p;
          state_r <= S_TR;
        end
        S_TR: begin
          neg_r   <= p_val[sdkj_pkg::VAL_W-1];
          mag_r   <= p_val[sdkj_pkg::VAL_W-1] ? 32'(-p_val) : 32'(p_val);
          state_r <= S_DM;
        end
        S_DM: begin
          prod_r  <= mul_p;
          state_r <= S_DE;
        end
        S_DE: begin
          est_r   <= prod_r[63:32];
          state_r <= S_DC;
        end
        S_DC: begin
          if (cos_sel_r) begin
            ct_r      <= term;
            cs_r      <= cs_r + term;
            cos_sel_r <= 1'b0;
            if (k_r == 3'(sdkj_pkg::TAYLOR_TERMS)) begin
              state_r <= S_ROT;
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= S_TM;
            end
          end else begin
            st_r      <= term;
            ss_r      <= ss_r + term;
            cos_sel_r <= 1'b1;
            state_r   <= S_TM;
          end
        end
        S_ROT: begin
          case (q_r[1:0])
            2'd0: begin sin_o <= ss_r;  cos_o <= cs_r;  end
            2'd1: begin sin_o <= cs_r;  cos_o <= -ss_r; end
            2'd2: begin sin_o <= -ss_r; cos_o <= -cs_r; end
            default: begin sin_o <= -cs_r; cos_o <= ss_r; end
          endcase
          done    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/sdkj_div.sv =====
module sdkj_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sdkj_pkg::val_t   num,
  input  sdkj_pkg::val_t   den,
  output logic             done,
  output sdkj_pkg::entry_t quo
);

  localparam int DVD_W = sdkj_pkg::VAL_W + 17;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                        busy_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [DVD_W-1:0]            dvd_r;
  logic [sdkj_pkg::VAL_W:0]    rem_r;
  logic [sdkj_pkg::VAL_W-1:0]  ud_r;
  logic                        neg_r;

  logic [sdkj_pkg::VAL_W-1:0]  un;
  logic [sdkj_pkg::VAL_W-1:0]  ud;
  logic [sdkj_pkg::VAL_W:0]    rem_sh;
  logic                        qbit;
  logic [DVD_W-1:0]            pos_max;

  assign un      = num[sdkj_pkg::VAL_W-1] ? sdkj_pkg::VAL_W'(-num) : sdkj_pkg::VAL_W'(num);
  assign ud      = den[sdkj_pkg::VAL_W-1] ? sdkj_pkg::VAL_W'(-den) : sdkj_pkg::VAL_W'(den);
  assign rem_sh  = {rem_r[sdkj_pkg::VAL_W-1:0], dvd_r[DVD_W-1]};
  assign qbit    = rem_sh >= {1'b0, ud_r};
  assign pos_max = (DVD_W'(1) << (sdkj_pkg::ENTRY_W - 1)) - DVD_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          // rounded quotient: (|n| * 2^16 + |d|/2) / |d|
          dvd_r  <= (DVD_W'(un) << 16) + DVD_W'(ud >> 1);
          rem_r  <= '0;
          ud_r   <= ud;
          neg_r  <= num[sdkj_pkg::VAL_W-1] != den[sdkj_pkg::VAL_W-1];
          cnt_r  <= CNT_W'(DVD_W);
          busy_r <= 1'b1;
        end
      end else if (cnt_r != '0) begin
        rem_r <= qbit ? rem_sh - {1'b0, ud_r} : rem_sh;
        dvd_r <= {dvd_r[DVD_W-2:0], qbit};
        cnt_r <= cnt_r - CNT_W'(1);
      end else begin
        if (ud_r == '0) begin
          quo <= '0;
        end else if (neg_r) begin
          if (dvd_r > pos_max) quo <= sdkj_pkg::entry_t'(sdkj_pkg::ENT_MIN);
          else quo <= -sdkj_pkg::entry_t'(dvd_r[sdkj_pkg::ENTRY_W-1:0]);
        end else begin
          if (dvd_r > pos_max) quo <= sdkj_pkg::entry_t'(sdkj_pkg::ENT_MAX);
          else quo <= sdkj_pkg::entry_t'(dvd_r[sdkj_pkg::ENTRY_W-1:0]);
        end
        done   <= 1'b1;
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/sdkj_back.sv =====
module sdkj_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  sdkj_pkg::angles_t  head,
  output logic               take,
  output logic               empty,
  input  logic               pop,
  output sdkj_pkg::row_res_t out_row
);

  typedef enum logic [3:0] {
    B_IDLE, B_TRIG, B_MUL, B_MWB, B_FIN, B_DIV1, B_DIV2, B_EMIT
  } state_t;

  state_t             state_r;
  sdkj_pkg::angles_t  ang_r;
  logic [1:0]         ang_idx_r;
  sdkj_pkg::val_t     sr_r, cr_r, sp_r, cp_r, sy_r, cy_r;
  sdkj_pkg::val_t     u_r [6];
  logic [2:0]         row_r;
  logic [2:0]         sub_r;
  sdkj_pkg::prod_t    prod_r;
  sdkj_pkg::entry_t   e1_r, e2_r, e3_r;

  sdkj_pkg::row_res_t oq_r [2];
  logic               oq_wr_r;
  logic               oq_rd_r;
  logic [1:0]         oq_cnt_r;

  logic               trig_start;
  sdkj_pkg::angle_t   trig_angle;
  logic               trig_done;
  sdkj_pkg::val_t     trig_sin;
  sdkj_pkg::val_t     trig_cos;
  logic               div_start;
  sdkj_pkg::val_t     div_num;
  logic               div_done;
  sdkj_pkg::entry_t   div_quo;

  sdkj_pkg::mop_t     mul_a;
  sdkj_pkg::mop_t     mul_b;
  sdkj_pkg::prod_t    mul_p;
  sdkj_pkg::val_t     opa, opb;
  logic               sing;
  logic               div_row;
  logic               oq_full;
  logic               oq_push;
  logic               oq_pop;
  logic [2:0]         nmul_cur;
  logic [2:0]         nmul_next;
  sdkj_pkg::row_res_t res;

  function automatic logic [2:0] nmul(logic [2:0] row);
    logic [2:0] n;
    case (row)
      3'd0, 3'd1: n = 3'd6;
      3'd2, 3'd3: n = 3'd2;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  sdkj_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (trig_angle),
    .done  (trig_done),
    .sin_o (trig_sin),
    .cos_o (trig_cos)
  );

  sdkj_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cp_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign sing      = (cp_r < sdkj_pkg::SING_LIM) && (cp_r > -sdkj_pkg::SING_LIM);
  assign div_row   = (row_r == 3'd3) || (row_r == 3'd5);
  assign nmul_cur  = nmul(row_r);
  assign nmul_next = nmul(row_r + 3'd1);
  assign take      = (state_r == B_IDLE) && head_valid;

  always_comb begin
    trig_start = 1'b0;
    trig_angle = head.roll;
    if (state_r == B_IDLE) begin
      trig_start = head_valid;
    end else if (state_r == B_TRIG && trig_done && ang_idx_r != 2'd2) begin
      trig_start = 1'b1;
      trig_angle = (ang_idx_r == 2'd0) ? ang_r.pitch : ang_r.yaw;
    end
  end

  assign div_start = ((state_r == B_FIN) && div_row && !sing)
                     || ((state_r == B_DIV1) && div_done);
  always_comb begin
    if (state_r == B_FIN) div_num = (row_r == 3'd3) ? u_r[0] : sr_r;
    else div_num = (row_r == 3'd3) ? u_r[1] : cr_r;
  end

  // rows 0 and 1 share a schedule with cos/sin of yaw swapped
  always_comb begin
    opa = (row_r == 3'd0) ? cy_r : sy_r;
    opb = (row_r == 3'd0) ? sy_r : cy_r;
    mul_a = '0;
    mul_b = '0;
    case (row_r)
      3'd0, 3'd1: begin
        case (sub_r)
          3'd0: begin mul_a = sdkj_pkg::mop_t'(opa);    mul_b = sdkj_pkg::mop_t'(cp_r); end
          3'd1: begin mul_a = sdkj_pkg::mop_t'(opa);    mul_b = sdkj_pkg::mop_t'(sp_r); end
          3'd2: begin mul_a = sdkj_pkg::mop_t'(u_r[1]); mul_b = sdkj_pkg::mop_t'(sr_r); end
          3'd3: begin mul_a = sdkj_pkg::mop_t'(opb);    mul_b = sdkj_pkg::mop_t'(cr_r); end
          3'd4: begin mul_a = sdkj_pkg::mop_t'(u_r[1]); mul_b = sdkj_pkg::mop_t'(cr_r); end
          default: begin mul_a = sdkj_pkg::mop_t'(opb); mul_b = sdkj_pkg::mop_t'(sr_r); end
        endcase
      end
      3'd2: begin
        mul_a = sdkj_pkg::mop_t'(cp_r);
        mul_b = (sub_r == 3'd0) ? sdkj_pkg::mop_t'(sr_r) : sdkj_pkg::mop_t'(cr_r);
      end
      3'd3: begin
        mul_a = (sub_r == 3'd0) ? sdkj_pkg::mop_t'(sr_r) : sdkj_pkg::mop_t'(cr_r);
        mul_b = sdkj_pkg::mop_t'(sp_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign oq_full = (oq_cnt_r == 2'd2);
  assign empty   = (oq_cnt_r == 2'd0);
  assign out_row = oq_r[oq_rd_r];
  assign oq_push = (state_r == B_EMIT) && !oq_full;
  assign oq_pop  = pop && !empty;

  always_comb begin
    res.row_index    = row_r;
    res.entry_first  = e1_r;
    res.entry_second = e2_r;
    res.entry_third  = e3_r;
    res.singular     = sing;
    res.last_row     = (row_r == 3'd5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_r[oq_wr_r] <= res;
        oq_wr_r       <= !oq_wr_r;
      end
      if (oq_pop) oq_rd_r <= !oq_rd_r;
      if (oq_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 2'd1;
      else if (!oq_push && oq_pop) oq_cnt_r <= oq_cnt_r - 2'd1;

      case (state_r)
        B_IDLE: begin
          if (head_valid) begin
            ang_r     <= head;
            ang_idx_r <= 2'd0;
            state_r   <= B_TRIG;
          end
        end
        B_TRIG: begin
          if (trig_done) begin
            case (ang_idx_r)
              2'd0: begin sr_r <= trig_sin; cr_r <= trig_cos; end
              2'd1: begin sp_r <= trig_sin; cp_r <= trig_cos; end
              default: begin sy_r <= trig_sin; cy_r <= trig_cos; end
            endcase
            if (ang_idx_r == 2'd2) begin
              row_r   <= 3'd0;
              sub_r   <= 3'd0;
              state_r <= B_MUL;
            end else begin
              ang_idx_r <= ang_idx_r + 2'd1;
            end
          end
        end
        B_MUL: begin
          prod_r  <= mul_p;
          state_r <= B_MWB;
        end
        B_MWB: begin
          u_r[sub_r] <= sdkj_pkg::rnd_q30(prod_r);
          if (sub_r == nmul_cur - 3'd1) begin
            state_r <= B_FIN;
          end else begin
            sub_r   <= sub_r + 3'd1;
            state_r <= B_MUL;
          end
        end
        B_FIN: begin
          case (row_r)
            3'd0: begin
              e1_r <= sdkj_pkg::q30_entry(u_r[0]);
              e2_r <= sdkj_pkg::q30_entry(u_r[2] - u_r[3]);
              e3_r <= sdkj_pkg::q30_entry(u_r[4] + u_r[5]);
            end
            3'd1: begin
              e1_r <= sdkj_pkg::q30_entry(u_r[0]);
              e2_r <= sdkj_pkg::q30_entry(u_r[2] + u_r[3]);
              e3_r <= sdkj_pkg::q30_entry(u_r[4] - u_r[5]);
            end
            3'd2: begin
              e1_r <= sdkj_pkg::q30_entry(-sp_r);
              e2_r <= sdkj_pkg::q30_entry(u_r[0]);
              e3_r <= sdkj_pkg::q30_entry(u_r[1]);
            end
            3'd3: begin
              e1_r <= sdkj_pkg::sat_entry(sdkj_pkg::ONE_Q16);
              e2_r <= '0;
              e3_r <= '0;
            end
            3'd4: begin
              e1_r <= '0;
              e2_r <= sdkj_pkg::q30_entry(cr_r);
              e3_r <= sdkj_pkg::q30_entry(-sr_r);
            end
            default: begin
              e1_r <= '0;
              e2_r <= '0;
              e3_r <= '0;
            end
          endcase
          state_r <= (div_row && !sing) ? B_DIV1 : B_EMIT;
        end
        B_DIV1: begin
          if (div_done) begin
            e2_r    <= div_quo;
            state_r <= B_DIV2;
          end
        end
        B_DIV2: begin
          if (div_done) begin
            e3_r    <= div_quo;
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (!oq_full) begin
            if (row_r == 3'd5) begin
              state_r <= B_IDLE;
            end else begin
              row_r   <= row_r + 3'd1;
              sub_r   <= 3'd0;
              state_r <= (nmul_next == 3'd0) ? B_FIN : B_MUL;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/six_dof_kinematic_jacobian.sv =====
// Kinematic matrix J of a ZYX Euler attitude, one row per result.
// Input side is a queue: drive roll/pitch/yaw (Q3.13 radians) with push while
// full is low; each transfer is one angle set. Result side is a queue too:
// while empty is low the oldest row is on the out_ ports, pop takes it.
// Each angle set yields six rows, row_index 0..5, last_row on row 5. Rows 0-2
// hold R, rows 3-5 hold T; entries are Q16.16, saturated. singular marks a
// pitch cosine that rounds to zero; the divided entries are then 0.
// Three sin/cos evaluations share one iterative unit (quadrant reduction,
// then 14 Taylor terms on one multiplier); the four divided entries of rows
// 3 and 5 come from a bit-serial divider. A two-entry input queue takes new
// sets while one is in work, and a two-entry result queue holds finished
// rows. When pop stays low the engine stops once two rows wait and the input
// queue fills, raising full. Reset empties both queues and idles the engine.
module six_dof_kinematic_jacobian (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic signed [15:0]      in_roll_angle,
  input  logic signed [15:0]      in_pitch_angle,
  input  logic signed [15:0]      in_yaw_angle,
  output logic                    empty,
  input  logic                    pop,
  output logic [2:0]              out_row_index,
  output logic signed [31:0]      out_entry_first,
  output logic signed [31:0]      out_entry_second,
  output logic signed [31:0]      out_entry_third,
  output logic                    out_singular,
  output logic                    out_last_row
);

  sdkj_pkg::angles_t  item;
  sdkj_pkg::angles_t  head;
  logic               head_valid;
  logic               take;
  sdkj_pkg::row_res_t out_row;

  assign item.roll  = in_roll_angle;
  assign item.pitch = in_pitch_angle;
  assign item.yaw   = in_yaw_angle;

  sdkj_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  sdkj_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .out_row    (out_row)
  );

  assign out_row_index    = out_row.row_index;
  assign out_entry_first  = out_row.entry_first;
  assign out_entry_second = out_row.entry_second;
  assign out_entry_third  = out_row.entry_third;
  assign out_singular     = out_row.singular;
  assign out_last_row     = out_row.last_row;

endmodule
